// ===== sv/olir_pkg.sv =====
package olir_pkg;

  // Default list capacity
  localparam int unsigned DefCapacity = 16;

  // Field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CntOutW   = 5;

  // Operation codes on the input
  localparam logic [OpW-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [OpW-1:0] OP_INS_BACK  = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE    = 2'd2;
  localparam logic [OpW-1:0] OP_DUMP      = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] ST_DONE      = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd3;
  localparam logic [StatusW-1:0] ST_ENTRY     = 3'd4;

  // Command kind after classification
  typedef enum logic [1:0] {
    K_INS_FRONT,
    K_INS_BACK,
    K_REMOVE,
    K_DUMP
  } kind_e;

  // One queued command
  typedef struct packed {
    kind_e                    kind;
    logic signed [ValueW-1:0] value;
  } cmd_t;

endpackage

// ===== sv/olir_front.sv =====
module olir_front import olir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OpW-1:0]           operation_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     q_valid_o,
  output cmd_t                     q_item_o,
  input  logic                     q_pop_i
);

  cmd_t       buf_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] fill_q;
  logic       push;
  cmd_t       cmd;

  // Classify the incoming operation
  always_comb begin
    cmd.value = value_i;
    case (operation_i)
      OP_INS_FRONT: cmd.kind = K_INS_FRONT;
      OP_INS_BACK:  cmd.kind = K_INS_BACK;
      OP_REMOVE:    cmd.kind = K_REMOVE;
      OP_DUMP:      cmd.kind = K_DUMP;
      default:      cmd.kind = K_DUMP;
    endcase
  end

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  // Store classified commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd;
    end
  end

  // Advance queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push, q_pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== sv/olir_back.sv =====
module olir_back import olir_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  cmd_t                     q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] data_o,
  output logic [CntOutW-1:0]       entry_count_o,
  output logic                     last_o,
  output logic [CntW-1:0]          cnt_o
);

  localparam int unsigned LvlN = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [CAPACITY-1:0]      match_q;
  logic signed [ValueW-1:0] cell_q [CAPACITY];
  logic signed [ValueW-1:0] nxt_w  [CAPACITY];
  logic signed [ValueW-1:0] prv_w  [CAPACITY];
  logic [CAPACITY-1:0]      pre_w  [LvlN+1];
  logic                     out_free;
  logic                     emit;
  logic [StatusW-1:0]       st;
  logic signed [ValueW-1:0] dat;
  logic                     lst;
  logic                     do_front, do_back, do_remove, do_rotate, do_match;
  logic                     full, empty;

  logic                     out_valid_q;
  logic [StatusW-1:0]       status_q;
  logic signed [ValueW-1:0] data_q;
  logic [CntOutW-1:0]       ecount_q;
  logic                     last_q;

  // Neighbor taps of each cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g < CAPACITY - 1) begin : g_n
      assign nxt_w[g] = cell_q[g+1];
    end else begin : g_w
      assign nxt_w[g] = cell_q[0];
    end
    if (g > 0) begin : g_p
      assign prv_w[g] = cell_q[g-1];
    end else begin : g_h
      assign prv_w[g] = q_item_i.value;
    end
  end

  // Mark cells at or behind the first match
  assign pre_w[0] = match_q;
  for (genvar l = 0; l < LvlN; l++) begin : g_pre
    assign pre_w[l+1] = pre_w[l] | (pre_w[l] << (1 << l));
  end

  assign full     = (cnt_q == CntW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one command at a time
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    st        = ST_DONE;
    dat       = '0;
    lst       = 1'b1;
    do_front  = 1'b0;
    do_back   = 1'b0;
    do_remove = 1'b0;
    do_rotate = 1'b0;
    do_match  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_item_i.kind)
            K_INS_FRONT, K_INS_BACK: begin
              emit = 1'b1;
              if (full) begin
                st = ST_FULL;
              end else begin
                cnt_d    = cnt_q + CntW'(1);
                do_front = (q_item_i.kind == K_INS_FRONT);
                do_back  = (q_item_i.kind == K_INS_BACK);
              end
            end
            K_REMOVE: begin
              if (empty) begin
                emit = 1'b1;
                st   = ST_EMPTY;
              end else begin
                do_match = 1'b1;
                state_d  = S_SHIFT;
              end
            end
            K_DUMP: begin
              if (empty) begin
                emit = 1'b1;
                st   = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (match_q == '0) begin
            st = ST_NOT_FOUND;
          end else begin
            do_remove = 1'b1;
            cnt_d     = cnt_q - CntW'(1);
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit      = 1'b1;
          st        = ST_ENTRY;
          dat       = cell_q[0];
          lst       = (idx_q == cnt_q - CntW'(1));
          do_rotate = 1'b1;
          idx_d     = idx_q + CntW'(1);
          if (lst) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Update the cell row: shift in, append, close a gap or rotate
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_front) begin
        cell_q[i] <= prv_w[i];
      end else if (do_back && (CntW'(i) == cnt_q)) begin
        cell_q[i] <= q_item_i.value;
      end else if (do_remove && pre_w[LvlN][i]) begin
        cell_q[i] <= nxt_w[i];
      end else if (do_rotate) begin
        cell_q[i] <= (CntW'(i) == cnt_q - CntW'(1)) ? cell_q[0] : nxt_w[i];
      end
    end
  end

  // Compare every live cell against the value to remove
  always_ff @(posedge clk_i) begin
    if (do_match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_q[i] <= (cell_q[i] == q_item_i.value) && (CntW'(i) < cnt_q);
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      status_q <= st;
      data_q   <= dat;
      ecount_q <= CntOutW'(cnt_d);
      last_q   <= lst;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_o        = data_q;
  assign entry_count_o = ecount_q;
  assign last_o        = last_q;
  assign cnt_o         = cnt_q;

endmodule

// ===== sv/ordered_list_insert_remove.sv =====
// Ordered list of up to CAPACITY signed 32-bit values, held front to back in a
// row of registers. Commands enter a two-entry queue and are executed one at a
// time by the list engine behind it. An insert at front or back is done as the
// engine takes the command, a remove first compares all cells and then closes
// the gap in one shift, and a dump takes a start step and then streams one entry
// per cycle by rotating the row while the output is not stalled. Results go out
// through an output register, so the queue keeps taking commands while a result
// waits.
module ordered_list_insert_remove import olir_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OpW-1:0]           operation_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] data_o,
  output logic [CntOutW-1:0]       entry_count_o,
  output logic                     last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            q_valid;
  cmd_t            q_item;
  logic            q_pop;
  logic [CntW-1:0] cnt;

  olir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  olir_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_o        (data_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o),
    .cnt_o         (cnt)
  );

`ifndef SYNTHESIS
  // List never grows past its capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // Every result other than a dump entry closes its command with zero data
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ENTRY) |-> last_o && (data_o == '0))
    else $error("single result not marked last or carries data");

  // A dump entry is only produced while the list holds entries
  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ENTRY) |-> (cnt != '0))
    else $error("dump entry from an empty list");

  // Nothing is taken from the queue while it is empty
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
